// File: sv/lzgd_pkg.sv
// Shared types and constants for the LZ77 gamma decompressor.
// Used by lzgd_parser and lz77_gamma_decompressor_core; no dependencies.
`default_nettype none

package lzgd_pkg;

  localparam int unsigned HistAw    = 16;  // history address width (64 Ki bytes)
  localparam int unsigned CountW    = 17;  // byte counts and positions
  localparam int unsigned AccW      = 16;  // field accumulator
  localparam int unsigned SmallW    = 5;   // bit counters and prefix count
  localparam int unsigned MaxPrefix = 15;

  // Largest number of bytes the window keeps.
  localparam logic [CountW-1:0] WindowSize   = 17'h10000;
  localparam logic [CountW-1:0] OutLengthRst = 17'h10000;

  typedef enum logic [1:0] {
    FUNC_BIT     = 2'd0,
    FUNC_DRAIN   = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY_WINDOW = 3'd1,
    ST_LONG_PREFIX  = 3'd2,
    ST_COPY_OVERRUN = 3'd3,
    ST_BAD_OFFSET   = 3'd4
  } status_e;

  // What one accepted transaction asks of the datapath.
  typedef struct packed {
    logic              emit;      // a result follows
    logic              from_mem;  // byte comes from the history read
    logic [7:0]        lit_byte;  // literal byte, or zero for an error
    logic              last;
    status_e           status;
    logic              wr_en;     // store the byte in history
    logic [HistAw-1:0] wr_addr;
    logic              rd_en;     // read history for a copy byte
    logic [HistAw-1:0] rd_addr;
  } step_t;

endpackage

`default_nettype wire

// File: sv/lz77_gamma_decompressor_core.sv
// Top level of the LZ77 gamma decompressor: stream ports, history memory,
// read/output pipeline. Depends on lzgd_pkg and lzgd_parser.
`default_nettype none

// The block takes one transaction per cycle on the slave side while
// s_axis_tready_o is high: tuser carries the function (supply a compressed
// bit, drain one copy byte, restart, or no operation) and tdata bit 0 carries
// the compressed bit, most significant bit of each source byte first. Decoded
// bytes leave on the master side through the read stage, which does the
// synchronous read of the 64 KiB history memory, and then the output register.
// Literals, copy bytes and error codes all take the same path, so results
// keep their order. Every stored byte is written to history when it moves
// into the output register; a copy read that hits the byte being written in
// that same cycle is forwarded, so overlapping copies (run-length style) work
// at full rate. s_axis_tready_o falls only while the output register holds an
// untaken result and the read stage is occupied. A malformed stream yields one
// result with a nonzero status and then nothing until a restart; the stream
// also ends after out_length bytes, with tlast on the final byte. History is
// never cleared; a copy only reaches bytes of the current stream. Write
// out_length only while no transaction is in flight.
module lz77_gamma_decompressor_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // configuration: out_length
  input  wire                        cfg_we_i,
  input  wire [lzgd_pkg::CountW-1:0] cfg_wdata_i,
  // compressed input
  input  wire                        s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire [7:0]                  s_axis_tdata_i,   // [0] stream_bit, [7:1] zero
  input  wire [1:0]                  s_axis_tuser_i,   // [1:0] func
  // decoded output
  output logic                       m_axis_tvalid_o,
  input  wire                        m_axis_tready_i,
  output logic [7:0]                 m_axis_tdata_o,   // [7:0] out_byte
  output logic                       m_axis_tlast_o,
  output logic [2:0]                 m_axis_tuser_o    // [2:0] status
);
  import lzgd_pkg::*;

  localparam int unsigned HistDepth = 1 << HistAw;

  logic [CountW-1:0] out_length_q;
  step_t             step;
  logic              in_acc;
  logic              s1_adv;
  logic              mem_we;
  logic [7:0]        s1_data;

  // Read stage
  logic              s1_valid_q;
  logic              s1_from_mem_q;
  logic [7:0]        s1_lit_q;
  logic              s1_last_q;
  status_e           s1_status_q;
  logic              s1_we_q;
  logic [HistAw-1:0] s1_waddr_q;
  logic              fwd_q;
  logic [7:0]        fwd_data_q;
  logic [7:0]        rdata_q;

  // Output register
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  status_e           out_status_q;

  logic [7:0]        hist_mem [HistDepth];

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_adv          = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  lzgd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .func_i       (func_e'(s_axis_tuser_i)),
    .stream_bit_i (s_axis_tdata_i[0]),
    .out_length_i (out_length_q),
    .step_o       (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_length_q <= OutLengthRst;
    end else if (cfg_we_i) begin
      out_length_q <= cfg_wdata_i;
    end
  end

  // Byte of the read stage: forwarded write, history read, or literal.
  always_comb begin
    if (!s1_from_mem_q) begin
      s1_data = s1_lit_q;
    end else if (fwd_q) begin
      s1_data = fwd_data_q;
    end else begin
      s1_data = rdata_q;
    end
  end

  // Commit the byte to history as it moves into the output register.
  assign mem_we = s1_valid_q && s1_we_q && s1_adv;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[s1_waddr_q] <= s1_data;
    end
    if (in_acc && step.rd_en) begin
      rdata_q <= hist_mem[step.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= in_acc && step.emit;
    end
  end

  // Payload of the read stage; forward when the read hits this cycle's write.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) begin
      s1_from_mem_q <= step.from_mem;
      s1_lit_q      <= step.lit_byte;
      s1_last_q     <= step.last;
      s1_status_q   <= step.status;
      s1_we_q       <= step.wr_en;
      s1_waddr_q    <= step.wr_addr;
      fwd_q         <= mem_we && (s1_waddr_q == step.rd_addr);
      fwd_data_q    <= s1_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_byte_q   <= s1_data;
      out_last_q   <= s1_last_q;
      out_status_q <= s1_status_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

`default_nettype wire

// File: sv/lzgd_parser.sv
// Bit-level parser of the compressed stream: flag, literal, gamma length,
// offset and copy bookkeeping. Depends on lzgd_pkg.
`default_nettype none

module lzgd_parser (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            accept_i,
  input  wire lzgd_pkg::func_e           func_i,
  input  wire                            stream_bit_i,
  input  wire [lzgd_pkg::CountW-1:0]     out_length_i,
  output lzgd_pkg::step_t                step_o
);
  import lzgd_pkg::*;

  typedef enum logic [5:0] {
    PH_FLAG    = 6'b000001,
    PH_LITERAL = 6'b000010,
    PH_PREFIX  = 6'b000100,
    PH_SUFFIX  = 6'b001000,
    PH_OFFSET  = 6'b010000,
    PH_COPY    = 6'b100000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   produced_q, produced_d;
  logic [CountW-1:0]   base_q, base_d;
  logic [SmallW-1:0]   left_q, left_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [SmallW-1:0]   prefix_q, prefix_d;
  logic [CountW-1:0]   remain_q, remain_d;
  logic [CountW-1:0]   src_q, src_d;
  logic                stopped_q, stopped_d;

  logic [CountW-1:0]   wnd;
  logic [SmallW-1:0]   off_bits;
  logic [AccW-1:0]     acc_sh;
  logic                len_done;
  logic [CountW-1:0]   len_val;
  logic                put;
  logic                put_done;
  logic [CountW-1:0]   prod_inc;
  logic [CountW-1:0]   slide_gap;
  logic [CountW:0]     end_pos;

  // Bit length of (w - 1): the offset width that covers a window of w bytes.
  function automatic logic [SmallW-1:0] offset_width(input logic [CountW-1:0] w);
    logic [CountW-1:0] wm1;
    logic [SmallW-1:0] n;
    wm1 = w - 1'b1;
    n   = '0;
    for (int i = 0; i < CountW; i++) begin
      if (wm1[i]) n = SmallW'(i + 1);
    end
    if (w == '0) n = '0;
    return n;
  endfunction

  assign wnd       = produced_q - base_q;
  assign off_bits  = offset_width(wnd);
  assign acc_sh    = {acc_q[AccW-2:0], stream_bit_i};
  assign prod_inc  = produced_q + 1'b1;
  assign slide_gap = prod_inc - base_q;

  always_comb begin
    phase_d    = phase_q;
    produced_d = produced_q;
    base_d     = base_q;
    left_d     = left_q;
    acc_d      = acc_q;
    prefix_d   = prefix_q;
    remain_d   = remain_q;
    src_d      = src_q;
    stopped_d  = stopped_q;
    len_done   = 1'b0;
    len_val    = '0;
    put        = 1'b0;
    put_done   = 1'b0;
    end_pos    = '0;
    step_o          = '0;
    step_o.status   = ST_OK;
    step_o.wr_addr  = produced_q[HistAw-1:0];
    step_o.rd_addr  = src_q[HistAw-1:0];

    if (func_i == FUNC_RESTART) begin
      phase_d    = PH_FLAG;
      produced_d = '0;
      base_d     = '0;
      left_d     = '0;
      acc_d      = '0;
      prefix_d   = '0;
      remain_d   = '0;
      src_d      = '0;
      stopped_d  = 1'b0;
    end else if (!stopped_q && func_i == FUNC_BIT) begin
      case (phase_q)
        PH_FLAG: begin
          if (!stream_bit_i) begin
            phase_d = PH_LITERAL;
            left_d  = SmallW'(8);
            acc_d   = '0;
          end else if (produced_q == base_q) begin
            stopped_d     = 1'b1;
            step_o.emit   = 1'b1;
            step_o.status = ST_EMPTY_WINDOW;
          end else begin
            phase_d  = PH_PREFIX;
            prefix_d = '0;
          end
        end
        PH_LITERAL: begin
          acc_d  = acc_sh;
          left_d = left_q - 1'b1;
          if (left_q == SmallW'(1)) begin
            put             = 1'b1;
            put_done        = 1'b1;
            step_o.lit_byte = acc_sh[7:0];
          end
        end
        PH_PREFIX: begin
          if (stream_bit_i) begin
            if (prefix_q >= SmallW'(MaxPrefix)) begin
              stopped_d     = 1'b1;
              step_o.emit   = 1'b1;
              step_o.status = ST_LONG_PREFIX;
            end else begin
              prefix_d = prefix_q + 1'b1;
            end
          end else begin
            acc_d = '0;
            if (prefix_q == '0) begin
              len_done = 1'b1;
              len_val  = CountW'(2);
            end else begin
              phase_d = PH_SUFFIX;
              left_d  = prefix_q;
            end
          end
        end
        PH_SUFFIX: begin
          acc_d  = acc_sh;
          left_d = left_q - 1'b1;
          if (left_q == SmallW'(1)) begin
            len_done = 1'b1;
            len_val  = (CountW'(1) << prefix_q) + {1'b0, acc_sh} + 1'b1;
          end
        end
        PH_OFFSET: begin
          acc_d  = acc_sh;
          left_d = left_q - 1'b1;
          if (left_q == SmallW'(1)) begin
            if ({1'b0, acc_sh} >= wnd) begin
              stopped_d     = 1'b1;
              step_o.emit   = 1'b1;
              step_o.status = ST_BAD_OFFSET;
            end else begin
              src_d   = base_q + {1'b0, acc_sh};
              phase_d = PH_COPY;
            end
          end
        end
        default: begin
          // hold: bits are dropped while a copy waits
        end
      endcase
    end else if (!stopped_q && func_i == FUNC_DRAIN) begin
      if (phase_q == PH_COPY && remain_q != '0) begin
        step_o.rd_en    = 1'b1;
        step_o.from_mem = 1'b1;
        src_d           = src_q + 1'b1;
        remain_d        = remain_q - 1'b1;
        put             = 1'b1;
        put_done        = (remain_q == CountW'(1));
      end
    end

    // Length complete: check against out_length, then set up the offset.
    if (len_done) begin
      remain_d = len_val;
      end_pos  = {1'b0, produced_q} + {1'b0, len_val};
      if (end_pos > {1'b0, out_length_i}) begin
        stopped_d     = 1'b1;
        step_o.emit   = 1'b1;
        step_o.status = ST_COPY_OVERRUN;
      end else if (off_bits == '0) begin
        src_d   = base_q;
        phase_d = PH_COPY;
      end else begin
        phase_d = PH_OFFSET;
        left_d  = off_bits;
        acc_d   = '0;
      end
    end

    // Store one byte, advance the count, slide the window after a whole item.
    if (put) begin
      step_o.emit  = 1'b1;
      step_o.wr_en = 1'b1;
      produced_d   = prod_inc;
      if (put_done) begin
        phase_d = PH_FLAG;
        if (slide_gap > WindowSize) base_d = prod_inc - WindowSize;
      end
      step_o.last = (prod_inc >= out_length_i);
      if (prod_inc >= out_length_i) stopped_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FLAG;
      produced_q <= '0;
      base_q     <= '0;
      left_q     <= '0;
      acc_q      <= '0;
      prefix_q   <= '0;
      remain_q   <= '0;
      src_q      <= '0;
      stopped_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      produced_q <= produced_d;
      base_q     <= base_d;
      left_q     <= left_d;
      acc_q      <= acc_d;
      prefix_q   <= prefix_d;
      remain_q   <= remain_d;
      src_q      <= src_d;
      stopped_q  <= stopped_d;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_lz77_gamma_decompressor_core.sv
// Self-checking testbench for lz77_gamma_decompressor_core: bit-serial LZ77
// streams in, decoded bytes checked against an in-bench decoder model.
// Depends on lzgd_pkg and the core RTL only.

module tb_lz77_gamma_decompressor_core;
  import lzgd_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int HoldCycles  = 400;
  localparam int SettleDelay = 8;

  // Decoder parse states of the in-bench model.
  typedef enum logic [2:0] {
    DEC_FLAG,
    DEC_LIT,
    DEC_LEN_PREFIX,
    DEC_LEN_BITS,
    DEC_OFFSET,
    DEC_COPY
  } parse_e;

  typedef struct packed {
    func_e func;
    logic  sbit;
  } comp_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_e    status;
  } dec_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CountW-1:0]  cfg_wdata = '0;
  logic               s_tvalid = 1'b0;
  wire                s_tready;
  logic [7:0]         s_tdata = '0;
  logic [1:0]         s_tuser = FUNC_NOP;
  wire                m_tvalid;
  logic               m_tready = 1'b0;
  wire  [7:0]         m_tdata;
  wire                m_tlast;
  wire  [2:0]         m_tuser;

  lz77_gamma_decompressor_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [0] stream_bit, [7:1] zero
    .s_axis_tuser_i  (s_tuser),   // [1:0] func
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [7:0] out_byte
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)    // [2:0] status
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model: state, configuration and history of the current stream
  // ---------------------------------------------------------------------------
  logic [7:0]        hist_mem [65536];
  logic [CountW-1:0] out_len_r;
  logic [CountW-1:0] prod_cnt;
  logic [CountW-1:0] win_base;
  logic [CountW-1:0] copy_left;
  logic [CountW-1:0] copy_src;
  logic [AccW-1:0]   acc;
  logic [SmallW-1:0] bits_left;
  logic [SmallW-1:0] prefix_cnt;
  parse_e            dec_st;
  logic              halted;

  // Decoded bytes still owed by the block, oldest first.
  dec_byte_t dec_q[$];

  comp_item_t comp_in_q[$];  // compressed-stream transactions not yet offered
  comp_item_t feed;
  dec_byte_t  want;

  int err_cnt = 0;
  int cyc_cnt = 0;
  int src_gap = 0;
  int snk_gap = 0;
  int hold_left = 0;
  int hold_req_cnt = 0;
  int hold_seen = 0;
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;

  // Stream generator bookkeeping.
  int gen_cnt = 0;    // bytes the generated stream has produced so far
  int gen_len = 0;    // out_length the generator builds against
  int gen_items = 0;

  task automatic report_err(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic void dec_clear();
    prod_cnt   = '0;
    win_base   = '0;
    dec_st     = DEC_FLAG;
    bits_left  = '0;
    acc        = '0;
    prefix_cnt = '0;
    copy_left  = '0;
    copy_src   = '0;
    halted     = 1'b0;
  endfunction

  function automatic void dec_fail(input status_e code);
    halted = 1'b1;
    dec_q.push_back('{data: 8'h00, last: 1'b0, status: code});
  endfunction

  // Store a decoded byte, slide the window after a whole token, mark the end.
  function automatic void dec_store(input logic [7:0] v, input logic done);
    logic fin;
    hist_mem[prod_cnt[HistAw-1:0]] = v;
    prod_cnt = prod_cnt + 1'b1;
    if (done) begin
      dec_st = DEC_FLAG;
      if (prod_cnt - win_base > WindowSize) win_base = prod_cnt - WindowSize;
    end
    fin = (prod_cnt >= out_len_r);
    if (fin) halted = 1'b1;
    dec_q.push_back('{data: v, last: fin, status: ST_OK});
  endfunction

  // Match length known: check it against out_length, then size the offset.
  function automatic void dec_len_done();
    int unsigned wnd;
    int          nb;
    wnd = prod_cnt - win_base;
    nb  = 0;
    if (int'(prod_cnt) + int'(copy_left) > int'(out_len_r)) begin
      dec_fail(ST_COPY_OVERRUN);
      return;
    end
    while (nb < 17 && (1 << nb) < wnd) nb++;
    if (nb == 0) begin
      copy_src = win_base;
      dec_st   = DEC_COPY;
    end else begin
      dec_st    = DEC_OFFSET;
      bits_left = nb;
      acc       = '0;
    end
  endfunction

  function automatic void dec_bit(input logic b);
    int unsigned wnd;
    wnd = prod_cnt - win_base;
    case (dec_st)
      DEC_FLAG: begin
        if (!b) begin
          dec_st    = DEC_LIT;
          bits_left = 5'd8;
          acc       = '0;
        end else if (prod_cnt == win_base) begin
          dec_fail(ST_EMPTY_WINDOW);
        end else begin
          dec_st     = DEC_LEN_PREFIX;
          prefix_cnt = '0;
        end
      end
      DEC_LIT: begin
        acc = {acc[AccW-2:0], b};
        bits_left--;
        if (bits_left == 0) dec_store(acc[7:0], 1'b1);
      end
      DEC_LEN_PREFIX: begin
        if (b) begin
          if (prefix_cnt >= MaxPrefix) dec_fail(ST_LONG_PREFIX);
          else prefix_cnt++;
        end else begin
          acc = '0;
          if (prefix_cnt == 0) begin
            copy_left = 17'd2;
            dec_len_done();
          end else begin
            dec_st    = DEC_LEN_BITS;
            bits_left = prefix_cnt;
          end
        end
      end
      DEC_LEN_BITS: begin
        acc = {acc[AccW-2:0], b};
        bits_left--;
        if (bits_left == 0) begin
          copy_left = (17'd1 << prefix_cnt) + acc + 17'd1;
          dec_len_done();
        end
      end
      DEC_OFFSET: begin
        acc = {acc[AccW-2:0], b};
        bits_left--;
        if (bits_left == 0) begin
          if (acc >= wnd) begin
            dec_fail(ST_BAD_OFFSET);
          end else begin
            copy_src = win_base + acc;
            dec_st   = DEC_COPY;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Apply one accepted transaction to the model; queue the byte it yields.
  function automatic void dec_item(input func_e f, input logic b);
    logic [7:0] v;
    if (f == FUNC_RESTART) begin
      dec_clear();
      return;
    end
    if (halted || f == FUNC_NOP) return;
    if (f == FUNC_BIT) begin
      if (dec_st != DEC_COPY) dec_bit(b);
    end else if (dec_st == DEC_COPY && copy_left != 0) begin
      v         = hist_mem[copy_src[HistAw-1:0]];
      copy_src  = copy_src + 1'b1;
      copy_left = copy_left - 1'b1;
      dec_store(v, copy_left == 0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stream generator: builds compressed transactions into comp_in_q
  // ---------------------------------------------------------------------------
  task automatic put(input func_e f, input logic b);
    comp_in_q.push_back('{func: f, sbit: b});
    gen_items++;
  endtask

  task automatic put_bits(input int unsigned val, input int n);
    for (int i = n - 1; i >= 0; i--) put(FUNC_BIT, val[i]);
  endtask

  task automatic put_restart();
    put(FUNC_RESTART, $urandom_range(0, 1));
    gen_cnt = 0;
  endtask

  task automatic put_literal(input logic [7:0] v);
    put(FUNC_BIT, 1'b0);
    put_bits(v, 8);
    gen_cnt++;
  endtask

  // Gamma code of a match length (2 and up): q ones, a zero, q low bits.
  task automatic put_length(input int len);
    int rest;
    int q;
    rest = len - 1;
    q    = 0;
    while ((rest >> (q + 1)) != 0) q++;
    for (int i = 0; i < q; i++) put(FUNC_BIT, 1'b1);
    put(FUNC_BIT, 1'b0);
    put_bits(rest - (1 << q), q);
  endtask

  function automatic int off_width(input int wnd);
    int nb;
    nb = 0;
    while (nb < 17 && (1 << nb) < wnd) nb++;
    return nb;
  endfunction

  // Whole match: flag, length, offset, then one drain per copied byte. With
  // noise on, slip ignored bits and no-ops in while the copy waits.
  task automatic put_match(input int len, input int off, input bit noisy);
    put(FUNC_BIT, 1'b1);
    put_length(len);
    put_bits(off, off_width(gen_cnt));
    if (noisy) put(FUNC_BIT, $urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) put(FUNC_NOP, $urandom_range(0, 1));
        else put(FUNC_BIT, $urandom_range(0, 1));
      end
      put(FUNC_DRAIN, $urandom_range(0, 1));
    end
    gen_cnt += len;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Malformed or cut-off token, always followed by a restart.
  task automatic put_broken();
    int room;
    int len;
    int nb;
    room = gen_len - gen_cnt;
    nb   = off_width(gen_cnt);
    case ($urandom_range(0, 5))
      0: begin
        put(FUNC_BIT, 1'b1);
        put_bits(16'hFFFF, 16);
      end
      1: begin
        len = room + $urandom_range(1, 20);
        if (len > 65536) len = 65536;
        put(FUNC_BIT, 1'b1);
        put_length(len);
      end
      2: begin
        if ((1 << nb) > gen_cnt) begin
          put(FUNC_BIT, 1'b1);
          put_length(2);
          put_bits($urandom_range(gen_cnt, (1 << nb) - 1), nb);
        end else begin
          put(FUNC_BIT, 1'b1);
          put(FUNC_BIT, 1'b1);
        end
      end
      3: begin
        put_restart();
        put(FUNC_BIT, 1'b1);
      end
      4: begin
        repeat ($urandom_range(1, 40)) begin
          case ($urandom_range(0, 5))
            0:       put(FUNC_DRAIN, $urandom_range(0, 1));
            1:       put(FUNC_NOP, $urandom_range(0, 1));
            default: put(FUNC_BIT, $urandom_range(0, 1));
          endcase
        end
      end
      default: begin
        put(FUNC_BIT, 1'b0);
        put_bits($urandom_range(0, 7), 3);
      end
    endcase
    put_restart();
  endtask

  // Mostly well-formed streams with random content, some noise mixed in.
  task automatic gen_stream(input int budget);
    int stop_at;
    int r;
    int room;
    int cap;
    int off;
    stop_at = gen_items + budget;
    put_restart();
    while (gen_items < stop_at) begin
      room = gen_len - gen_cnt;
      r    = $urandom_range(0, 99);
      if (room <= 0) begin
        // stream over: poke it once in a while, then start the next one
        if ($urandom_range(0, 2) == 0) begin
          put(FUNC_BIT, $urandom_range(0, 1));
          put(FUNC_DRAIN, $urandom_range(0, 1));
        end
        put_restart();
      end else if (gen_cnt == 0 || r < 35 || room < 2) begin
        put_literal(rand_byte());
      end else if (r < 88) begin
        cap = room;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: if (cap > 8) cap = 8;
          6, 7, 8:          if (cap > 64) cap = 64;
          default:          if (cap > 600) cap = 600;
        endcase
        case ($urandom_range(0, 5))
          0, 1:    off = gen_cnt - 1;
          2:       off = 0;
          default: off = $urandom_range(0, gen_cnt - 1);
        endcase
        put_match($urandom_range(2, cap), off, r[0]);
      end else if (r < 92) begin
        if (r[0]) put(FUNC_DRAIN, $urandom_range(0, 1));
        else put(FUNC_NOP, $urandom_range(0, 1));
      end else begin
        put_broken();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer queued transactions, with random gaps while enabled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= FUNC_NOP;
      src_gap  <= 0;
    end else begin
      // predict at the edge that completes the transaction
      if (s_tvalid && s_tready) dec_item(func_e'(s_tuser), s_tdata[0]);
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          s_tvalid <= 1'b0;
          src_gap  <= src_gap - 1;
        end else if (comp_in_q.size() != 0) begin
          feed = comp_in_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= feed.func;
          s_tdata  <= {7'b0, feed.sbit};
          if (src_idle_en && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 17);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      snk_gap   <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen <= hold_req_cnt;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap  <= snk_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (snk_idle_en && $urandom_range(0, 7) == 0) snk_gap <= $urandom_range(1, 17);
    end
  end

  // Compare every accepted byte with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (dec_q.size() == 0) begin
        report_err($sformatf("unexpected byte %02h last %0b status %0d",
                             m_tdata, m_tlast, m_tuser));
      end else begin
        want = dec_q.pop_front();
        if (m_tdata !== want.data)
          report_err($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
        if (m_tlast !== want.last)
          report_err($sformatf("last %0b, want %0b", m_tlast, want.last));
        if (m_tuser !== want.status)
          report_err($sformatf("status %0d, want %0d", m_tuser, want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cyc_cnt, dec_q.size());
      $display("tb_lz77_gamma_decompressor_core: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  // Wait until every transaction is taken and every byte has come out, then
  // leave room for a transaction that yields nothing to clear the pipeline.
  task automatic settle();
    do @(negedge clk_i); while (comp_in_q.size() != 0 || s_tvalid || dec_q.size() != 0);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  task automatic set_out_length(input logic [CountW-1:0] v);
    settle();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    out_len_r = v;
    gen_len   = v;
    @(negedge clk_i);
  endtask

  initial begin
    logic [CountW-1:0] olen;
    int                wait_cnt;
    dec_clear();
    out_len_r = OutLengthRst;
    gen_len   = OutLengthRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // out_length 0 ends the stream at the first byte; later bits and drains
    // must stay silent
    set_out_length(17'd0);
    put_restart();
    put_literal(8'hA5);
    put(FUNC_BIT, 1'b1);
    put(FUNC_DRAIN, 1'b0);
    put(FUNC_NOP, 1'b1);

    set_out_length(OutLengthRst);
    // match flag with nothing decoded yet
    put_restart();
    put(FUNC_BIT, 1'b1);
    // one-byte window: no offset bits; drain with no copy pending is ignored
    put_restart();
    put_literal(8'h00);
    put(FUNC_DRAIN, 1'b1);
    put_match(2, 0, 1'b1);
    // overlapping copy from the newest byte
    put_literal(8'hFF);
    put_match(3, 3, 1'b1);
    // sixteenth prefix one
    put(FUNC_BIT, 1'b1);
    put_bits(16'hFFFF, 16);
    // longest legal prefix, but the copy overruns out_length
    put_restart();
    put_literal(8'h5A);
    put(FUNC_BIT, 1'b1);
    put_length(65536);
    // offset equal to the window size
    put_restart();
    put_literal(8'h01);
    put_literal(8'h80);
    put_literal(8'h7E);
    put(FUNC_BIT, 1'b1);
    put_length(2);
    put_bits(3, 2);

    set_out_length(17'd1);
    put_restart();
    put_literal(8'h3C);
    put_literal(8'h11);

    // lower out_length under a running stream: next byte ends it
    set_out_length(OutLengthRst);
    put_restart();
    repeat (4) put_literal(rand_byte());
    set_out_length(17'd2);
    put_literal(8'hC3);

    // Random phases; the last two run without any idling.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0:       olen = OutLengthRst;
        1:       olen = $urandom_range(1, 12);
        2:       olen = $urandom_range(40, 300);
        3:       olen = $urandom_range(300, 5000);
        default: olen = $urandom_range(2, 40);
      endcase
      set_out_length(olen);
      src_idle_en = (ph < 8) && (ph != 5);
      snk_idle_en = (ph < 8) && (ph != 6);
      // stall the output for a long stretch while the sender keeps going
      if (ph == 2) hold_req_cnt++;
      gen_stream(130);
      settle();
    end

    wait_cnt = 0;
    do begin
      @(negedge clk_i);
      wait_cnt++;
    end while ((comp_in_q.size() != 0 || s_tvalid || dec_q.size() != 0) && wait_cnt < 20000);
    repeat (SettleDelay) @(posedge clk_i);
    if (dec_q.size() != 0) report_err($sformatf("%0d decoded bytes never came", dec_q.size()));
    if (err_cnt == 0) begin
      $display("tb_lz77_gamma_decompressor_core: done, clean");
    end else begin
      $display("tb_lz77_gamma_decompressor_core: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
sv/lzgd_pkg.sv
sv/lzgd_parser.sv
sv/lz77_gamma_decompressor_core.sv
tb/tb_lz77_gamma_decompressor_core.sv
